// ----- rtl/lcbc_pkg.sv -----
// ----------------------------------------------------------------------------
// lcbc_pkg
// Shared types and constants of the breathing LED command controller: mode
// and status codes, register indexes, control characters and command text.
// ----------------------------------------------------------------------------
package lcbc_pkg;

    // LED mode, as reported on the result channel
    typedef enum logic [1:0] {
        MODE_ON     = 2'd0,
        MODE_OFF    = 2'd1,
        MODE_BREATH = 2'd2
    } t_mode;

    // Command status, as reported on the result channel
    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_ON       = 3'd1,
        ST_OFF      = 3'd2,
        ST_BREATH   = 3'd3,
        ST_UNKNOWN  = 3'd4,
        ST_OVERFLOW = 3'd5
    } t_status;

    // Configuration register indexes
    localparam logic CFG_PERIOD    = 1'b0;
    localparam logic CFG_STEP_SIZE = 1'b1;

    // Register widths and reset values
    localparam int PERIOD_W = 16;
    localparam int STEP_W   = 10;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd999;
    localparam logic [STEP_W-1:0]   STEP_RESET   = 10'd10;

    // Control characters
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    // Command text, left aligned in a ten character field
    localparam int CMD_MAX = 10;
    localparam logic [8*CMD_MAX-1:0] CMD_ON_STR     = {"LED_ON", 32'h0};
    localparam logic [8*CMD_MAX-1:0] CMD_OFF_STR    = {"LED_OFF", 24'h0};
    localparam logic [8*CMD_MAX-1:0] CMD_BREATH_STR = {"LED_", "BREATH"};
    localparam logic [3:0] CMD_ON_LEN     = 4'd6;
    localparam logic [3:0] CMD_OFF_LEN    = 4'd7;
    localparam logic [3:0] CMD_BREATH_LEN = 4'd10;

    // Character of a command at a position below CMD_MAX
    function automatic logic [7:0] cmd_char(input logic [8*CMD_MAX-1:0] str,
                                            input logic [3:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        for (int k = 0; k < CMD_MAX; k++) begin
            if (pos == 4'(k)) begin
                ch = str[8*(CMD_MAX-1-k) +: 8];
            end
        end
        return ch;
    endfunction

endpackage

// ----- rtl/lcbc_line_match.sv -----
// ----------------------------------------------------------------------------
// lcbc_line_match
// Line assembly and command matching. Instead of storing the line, one flag
// per command tracks whether every byte so far equals the command text.
// ----------------------------------------------------------------------------
module lcbc_line_match
    import lcbc_pkg::*;
#(
    parameter int LINE_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_byte_en,
    input  logic [7:0] i_byte,
    output t_status    o_status
);

    localparam int CW = $clog2(LINE_DEPTH);
    localparam logic [CW-1:0] FULL_COUNT = CW'(LINE_DEPTH - 1);

    logic [CW-1:0] r_count, n_count;
    logic          r_on_ok, n_on_ok;
    logic          r_off_ok, n_off_ok;
    logic          r_br_ok, n_br_ok;

    logic       full;
    logic [3:0] pos;
    logic       in_cmd;

    assign full   = (r_count >= FULL_COUNT);
    assign in_cmd = (r_count < CW'(CMD_BREATH_LEN));
    assign pos    = r_count[3:0];

    // Classify the byte and work out the next line state
    always_comb begin
        n_count  = r_count;
        n_on_ok  = r_on_ok;
        n_off_ok = r_off_ok;
        n_br_ok  = r_br_ok;
        o_status = ST_NONE;
        if (full) begin
            o_status = ST_OVERFLOW;
            n_count  = '0;
            n_on_ok  = 1'b1;
            n_off_ok = 1'b1;
            n_br_ok  = 1'b1;
        end else if (i_byte == CHAR_LF) begin
            if (r_on_ok && r_count == CW'(CMD_ON_LEN)) begin
                o_status = ST_ON;
            end else if (r_off_ok && r_count == CW'(CMD_OFF_LEN)) begin
                o_status = ST_OFF;
            end else if (r_br_ok && r_count == CW'(CMD_BREATH_LEN)) begin
                o_status = ST_BREATH;
            end else begin
                o_status = ST_UNKNOWN;
            end
            n_count  = '0;
            n_on_ok  = 1'b1;
            n_off_ok = 1'b1;
            n_br_ok  = 1'b1;
        end else if (i_byte != CHAR_CR) begin
            n_count  = r_count + 1'b1;
            n_on_ok  = r_on_ok && in_cmd && (pos < CMD_ON_LEN)
                       && (i_byte == cmd_char(CMD_ON_STR, pos));
            n_off_ok = r_off_ok && in_cmd && (pos < CMD_OFF_LEN)
                       && (i_byte == cmd_char(CMD_OFF_STR, pos));
            n_br_ok  = r_br_ok && in_cmd
                       && (i_byte == cmd_char(CMD_BREATH_STR, pos));
        end
    end

    // Hold line state; advance only on a byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_on_ok  <= 1'b1;
            r_off_ok <= 1'b1;
            r_br_ok  <= 1'b1;
        end else if (i_byte_en) begin
            r_count  <= n_count;
            r_on_ok  <= n_on_ok;
            r_off_ok <= n_off_ok;
            r_br_ok  <= n_br_ok;
        end
    end

endmodule

// ----- rtl/lcbc_breath_step.sv -----
// ----------------------------------------------------------------------------
// lcbc_breath_step
// Breathing duty generator: one step per tick, clamped at zero and at the
// period with a direction change, and the compare value that follows.
// ----------------------------------------------------------------------------
module lcbc_breath_step
    import lcbc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tick_en,
    input  logic [PERIOD_W-1:0] i_period,
    input  logic [STEP_W-1:0]   i_step,
    output logic [PERIOD_W-1:0] o_compare
);

    logic [PERIOD_W-1:0] r_duty, n_duty;
    logic                r_rising, n_rising;

    logic [PERIOD_W:0] sum;
    logic [PERIOD_W:0] diff;
    logic [PERIOD_W:0] nd;
    logic              at_floor;
    logic              at_ceiling;

    assign sum  = {1'b0, r_duty} + {{(PERIOD_W + 1 - STEP_W){1'b0}}, i_step};
    assign diff = {1'b0, r_duty} - {{(PERIOD_W + 1 - STEP_W){1'b0}}, i_step};
    assign nd   = r_rising ? sum : diff;

    // Floor when the step lands at or below zero
    assign at_floor   = r_rising ? (sum == '0)
                                 : (r_duty <= {{(PERIOD_W - STEP_W){1'b0}}, i_step});
    assign at_ceiling = (nd >= {1'b0, i_period});

    // Clamp and turn around at either end
    always_comb begin
        if (at_floor) begin
            n_duty   = '0;
            n_rising = 1'b1;
        end else if (at_ceiling) begin
            n_duty   = i_period;
            n_rising = 1'b0;
        end else begin
            n_duty   = nd[PERIOD_W-1:0];
            n_rising = r_rising;
        end
    end

    // New duty never exceeds the period
    assign o_compare = i_period - n_duty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty   <= '0;
            r_rising <= 1'b1;
        end else if (i_tick_en) begin
            r_duty   <= n_duty;
            r_rising <= n_rising;
        end
    end

endmodule

// ----- rtl/led_command_breathing_controller_unit.sv -----
// ----------------------------------------------------------------------------
// led_command_breathing_controller_unit
// Serial command line controller for an active-low LED with a breathing mode.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+-----------------------------
//   input    | in        | i_in_valid / o_in_stall | i_func, i_rx_byte
//   result   | out       | o_out_valid / i_out_stall | o_compare_value, o_led_mode,
//            |           |                        | o_command_status
//   config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while i_out_stall is low; each item passes from
// transfer into the input register, then through the match or duty step logic
// into the result register. Synchronous reset sets mode off and compare to
// 999 and needs no clearing pass. A stalled result holds the result register
// and the input register, so the input stalls only while both are full.
// ----------------------------------------------------------------------------
module led_command_breathing_controller_unit
    import lcbc_pkg::*;
#(
    parameter int LINE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [7:0]  i_rx_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_compare_value,
    output logic [1:0]  o_led_mode,
    output logic [2:0]  o_command_status,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Input register
    logic       r_in_valid;
    logic       r_func;
    logic [7:0] r_byte;

    // Result register
    logic          r_out_valid;
    logic [15:0]   r_out_compare;
    t_mode         r_out_mode;
    t_status       r_out_status;

    // Controller state and configuration
    t_mode               r_mode, n_mode;
    logic [PERIOD_W-1:0] r_compare, n_compare;
    logic [PERIOD_W-1:0] r_period;
    logic [STEP_W-1:0]   r_step;

    logic    advance;
    logic    load_in;
    logic    byte_en;
    logic    tick_en;
    t_status line_status;
    t_status n_status;
    logic [PERIOD_W-1:0] breath_compare;

    // Move the item on when the result register is free or being taken
    assign advance = r_in_valid && (!r_out_valid || !i_out_stall);
    assign load_in = !r_in_valid || advance;
    assign byte_en = advance && !r_func;
    assign tick_en = advance && r_func && (r_mode == MODE_BREATH);

    assign o_in_stall  = !load_in;
    assign o_cfg_ready = 1'b1;

    lcbc_line_match #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_line_match (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_en (byte_en),
        .i_byte    (r_byte),
        .o_status  (line_status)
    );

    lcbc_breath_step u_breath_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick_en (tick_en),
        .i_period  (r_period),
        .i_step    (r_step),
        .o_compare (breath_compare)
    );

    // Apply the command or the tick to mode and compare value
    always_comb begin
        n_mode    = r_mode;
        n_compare = r_compare;
        n_status  = ST_NONE;
        if (!r_func) begin
            n_status = line_status;
            unique case (line_status)
                ST_ON: begin
                    n_mode    = MODE_ON;
                    n_compare = '0;
                end
                ST_OFF: begin
                    n_mode    = MODE_OFF;
                    n_compare = r_period;
                end
                ST_BREATH: begin
                    n_mode = MODE_BREATH;
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end else if (r_mode == MODE_BREATH) begin
            n_compare = breath_compare;
        end
    end

    // Capture the incoming transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (load_in) begin
            r_in_valid <= i_in_valid;
        end
        if (load_in && i_in_valid) begin
            r_func <= i_func;
            r_byte <= i_rx_byte;
        end
    end

    // Update state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_mode      <= MODE_OFF;
            r_compare   <= PERIOD_RESET;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_compare   <= n_compare;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_out_compare <= n_compare;
            r_out_mode    <= n_mode;
            r_out_status  <= n_status;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
            r_step   <= STEP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_PERIOD) begin
                r_period <= i_cfg_data;
            end
            if (i_cfg_index == CFG_STEP_SIZE) begin
                r_step <= i_cfg_data[STEP_W-1:0];
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_compare_value  = r_out_compare;
    assign o_led_mode       = r_out_mode;
    assign o_command_status = r_out_status;

endmodule
